/* hw/rtl/dtse_pkg.sv */
// dtse_pkg: word types, button and mode codes, cursor positions and field limits
// for the date/time set editor. No dependencies.
package dtse_pkg;

  typedef enum logic [2:0] {
    BTN_NONE  = 3'd0,
    BTN_UP    = 3'd1,
    BTN_RIGHT = 3'd2,
    BTN_DOWN  = 3'd3,
    BTN_LEFT  = 3'd4,
    BTN_SAVE  = 3'd5
  } button_e;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_BUTTON = 1'b1
  } mode_e;

  localparam logic [2:0] CUR_DAY    = 3'd0;
  localparam logic [2:0] CUR_MONTH  = 3'd1;
  localparam logic [2:0] CUR_YEAR   = 3'd2;
  localparam logic [2:0] CUR_HOUR   = 3'd3;
  localparam logic [2:0] CUR_MINUTE = 3'd4;
  localparam logic [2:0] CUR_SECOND = 3'd5;
  localparam logic [2:0] CUR_SAVED  = 3'd6;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;

  typedef struct packed {
    logic        mode;
    logic [2:0]  button;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  shown_day;
    logic [3:0]  shown_month;
    logic [13:0] shown_year;
    logic [4:0]  shown_hour;
    logic [5:0]  shown_minute;
    logic [5:0]  shown_second;
    logic [2:0]  cursor;
    logic        commit;
  } out_word_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  cursor;
  } held_t;

  localparam held_t HELD_RESET = '{
    day:    5'd1,
    month:  4'd1,
    year:   14'd0,
    hour:   5'd0,
    minute: 6'd0,
    second: 6'd0,
    cursor: CUR_DAY
  };

endpackage

/* hw/rtl/dtse_edit.sv */
// dtse_edit: next editor state and commit flag for one input word.
// Pure combinational. Depends on dtse_pkg.
module dtse_edit (
  input  dtse_pkg::held_t    held_i,
  input  dtse_pkg::in_word_t word_i,
  output dtse_pkg::held_t    held_o,
  output logic               commit_o
);

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      len = 5'd30;
    end else if (m == 4'd2) begin
      len = 5'd29;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [3:0] m);
    logic [4:0] len;
    len = month_len(m);
    return (d > len) ? len : d;
  endfunction

  logic [13:0] yr_inc, yr_dec, yr_mu, yr_md;
  logic [3:0]  mon_up, mon_dn;
  logic [4:0]  hr_inc, hr_dec;
  logic [5:0]  mi_inc, mi_dec, se_inc, se_dec;
  logic [4:0]  hr_mi_up, hr_mi_dn;
  logic        mi_wrap_up, mi_wrap_dn, se_wrap_up, se_wrap_dn;
  logic [3:0]  ld_month;
  logic [4:0]  ld_day;

  assign yr_inc = (held_i.year < dtse_pkg::YEAR_MAX) ? held_i.year + 14'd1 : held_i.year;
  assign yr_dec = (held_i.year > 14'd0) ? held_i.year - 14'd1 : held_i.year;
  assign mon_up = (held_i.month >= dtse_pkg::MONTH_MAX) ? 4'd1 : held_i.month + 4'd1;
  assign yr_mu  = (held_i.month >= dtse_pkg::MONTH_MAX) ? yr_inc : held_i.year;
  assign mon_dn = (held_i.month <= 4'd1) ? dtse_pkg::MONTH_MAX : held_i.month - 4'd1;
  assign yr_md  = (held_i.month <= 4'd1) ? yr_dec : held_i.year;

  assign hr_inc = (held_i.hour >= dtse_pkg::HOUR_MAX) ? 5'd0 : held_i.hour + 5'd1;
  assign hr_dec = (held_i.hour == 5'd0) ? dtse_pkg::HOUR_MAX : held_i.hour - 5'd1;

  assign mi_wrap_up = (held_i.minute >= dtse_pkg::MINSEC_MAX);
  assign mi_wrap_dn = (held_i.minute == 6'd0);
  assign mi_inc     = mi_wrap_up ? 6'd0 : held_i.minute + 6'd1;
  assign mi_dec     = mi_wrap_dn ? dtse_pkg::MINSEC_MAX : held_i.minute - 6'd1;
  assign hr_mi_up   = mi_wrap_up ? hr_inc : held_i.hour;
  assign hr_mi_dn   = mi_wrap_dn ? hr_dec : held_i.hour;

  assign se_wrap_up = (held_i.second >= dtse_pkg::MINSEC_MAX);
  assign se_wrap_dn = (held_i.second == 6'd0);
  assign se_inc     = se_wrap_up ? 6'd0 : held_i.second + 6'd1;
  assign se_dec     = se_wrap_dn ? dtse_pkg::MINSEC_MAX : held_i.second - 6'd1;

  // load path saturation
  assign ld_month = (word_i.load_month < 4'd1) ? 4'd1 :
                    (word_i.load_month > dtse_pkg::MONTH_MAX) ? dtse_pkg::MONTH_MAX :
                    word_i.load_month;
  assign ld_day   = clamp_day((word_i.load_day < 5'd1) ? 5'd1 : word_i.load_day, ld_month);

  always_comb begin
    logic up;
    held_o   = held_i;
    commit_o = 1'b0;
    up       = (word_i.button == dtse_pkg::BTN_UP);
    if (word_i.mode == dtse_pkg::MODE_LOAD) begin
      held_o.month  = ld_month;
      held_o.day    = ld_day;
      held_o.year   = (word_i.load_year > dtse_pkg::YEAR_MAX) ? dtse_pkg::YEAR_MAX
                                                              : word_i.load_year;
      held_o.hour   = (word_i.load_hour > dtse_pkg::HOUR_MAX) ? dtse_pkg::HOUR_MAX
                                                              : word_i.load_hour;
      held_o.minute = (word_i.load_minute > dtse_pkg::MINSEC_MAX) ? dtse_pkg::MINSEC_MAX
                                                                  : word_i.load_minute;
      held_o.second = (word_i.load_second > dtse_pkg::MINSEC_MAX) ? dtse_pkg::MINSEC_MAX
                                                                  : word_i.load_second;
      held_o.cursor = dtse_pkg::CUR_DAY;
    end else begin
      unique case (word_i.button)
        dtse_pkg::BTN_UP, dtse_pkg::BTN_DOWN: begin
          unique case (held_i.cursor)
            dtse_pkg::CUR_DAY: begin
              if (up) begin
                if (held_i.day >= month_len(held_i.month)) begin
                  held_o.day   = 5'd1;
                  held_o.month = mon_up;
                  held_o.year  = yr_mu;
                end else begin
                  held_o.day = held_i.day + 5'd1;
                end
              end else begin
                if (held_i.day <= 5'd1) begin
                  held_o.month = mon_dn;
                  held_o.year  = yr_md;
                  held_o.day   = month_len(mon_dn);
                end else begin
                  held_o.day = held_i.day - 5'd1;
                end
              end
            end
            dtse_pkg::CUR_MONTH: begin
              if (up) begin
                held_o.month = mon_up;
                held_o.year  = yr_mu;
                held_o.day   = clamp_day(held_i.day, mon_up);
              end else begin
                held_o.month = mon_dn;
                held_o.year  = yr_md;
                held_o.day   = clamp_day(held_i.day, mon_dn);
              end
            end
            dtse_pkg::CUR_YEAR: begin
              held_o.year = up ? yr_inc : yr_dec;
            end
            dtse_pkg::CUR_HOUR: begin
              held_o.hour = up ? hr_inc : hr_dec;
            end
            dtse_pkg::CUR_MINUTE: begin
              held_o.minute = up ? mi_inc : mi_dec;
              held_o.hour   = up ? hr_mi_up : hr_mi_dn;
            end
            dtse_pkg::CUR_SECOND: begin
              held_o.second = up ? se_inc : se_dec;
              if (up && se_wrap_up) begin
                held_o.minute = mi_inc;
                held_o.hour   = hr_mi_up;
              end else if (!up && se_wrap_dn) begin
                held_o.minute = mi_dec;
                held_o.hour   = hr_mi_dn;
              end
            end
            default: ;  // saved: no change
          endcase
        end
        dtse_pkg::BTN_RIGHT: begin
          if (held_i.cursor >= dtse_pkg::CUR_SAVED) begin
            held_o.cursor = dtse_pkg::CUR_SAVED;
          end else if (held_i.cursor == dtse_pkg::CUR_SECOND) begin
            held_o.cursor = dtse_pkg::CUR_DAY;
          end else begin
            held_o.cursor = held_i.cursor + 3'd1;
          end
        end
        dtse_pkg::BTN_LEFT: begin
          if (held_i.cursor == dtse_pkg::CUR_DAY || held_i.cursor > dtse_pkg::CUR_SECOND) begin
            held_o.cursor = dtse_pkg::CUR_SECOND;
          end else begin
            held_o.cursor = held_i.cursor - 3'd1;
          end
        end
        dtse_pkg::BTN_SAVE: begin
          held_o.cursor = dtse_pkg::CUR_SAVED;
          commit_o      = 1'b1;
        end
        default: ;  // none or unused codes
      endcase
    end
  end

endmodule

/* hw/rtl/date_time_set_editor.sv */
// date_time_set_editor: input register, edit logic, held state and result register.
// Depends on dtse_pkg and dtse_edit.
//
//   channel | valid       | stall       | word
//   --------+-------------+-------------+------------
//   input   | in_valid_i  | in_stall_o  | in_word_i
//   result  | out_valid_o | out_stall_i | out_word_o
//
// One word per cycle unless the result stalls; a taken word sits in the input register, then the result register.
// The held date, time and cursor update in the cycle a word moves into the result register.
// Reset puts the editor at 01/01/0000 00:00:00, cursor on day, both stages empty.
// A stalled result holds; the input stage keeps taking words until it too is full.
module date_time_set_editor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dtse_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dtse_pkg::out_word_t out_word_o
);

  logic                in_valid_q, in_valid_d;
  dtse_pkg::in_word_t  in_word_q;
  logic                out_valid_q, out_valid_d;
  dtse_pkg::out_word_t out_word_q;
  dtse_pkg::held_t     held_q, held_d;
  dtse_pkg::held_t     held_next;
  logic                commit;
  logic                advance, in_take;

  dtse_edit u_edit (
    .held_i   (held_q),
    .word_i   (in_word_q),
    .held_o   (held_next),
    .commit_o (commit)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
    held_d      = advance ? held_next : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= dtse_pkg::HELD_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q.shown_day    <= held_next.day;
      out_word_q.shown_month  <= held_next.month;
      out_word_q.shown_year   <= held_next.year;
      out_word_q.shown_hour   <= held_next.hour;
      out_word_q.shown_minute <= held_next.minute;
      out_word_q.shown_second <= held_next.second;
      out_word_q.cursor       <= held_next.cursor;
      out_word_q.commit       <= commit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* hw/rtl/dtse_checker.sv */
// dtse_sva: port-level assertions for date_time_set_editor, bound to the top level.
// Depends on dtse_pkg.
module dtse_sva (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dtse_pkg::out_word_t out_word_o
);

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without result backpressure");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result word changed");

  a_commit_saved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.commit) |-> (out_word_o.cursor == dtse_pkg::CUR_SAVED))
    else $error("commit without saved cursor");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.cursor <= dtse_pkg::CUR_SAVED &&
                     out_word_o.shown_hour <= dtse_pkg::HOUR_MAX &&
                     out_word_o.shown_minute <= dtse_pkg::MINSEC_MAX &&
                     out_word_o.shown_second <= dtse_pkg::MINSEC_MAX &&
                     out_word_o.shown_month >= 4'd1 &&
                     out_word_o.shown_month <= dtse_pkg::MONTH_MAX &&
                     out_word_o.shown_day >= 5'd1 &&
                     out_word_o.shown_year <= dtse_pkg::YEAR_MAX))
    else $error("result field out of range");

endmodule

bind date_time_set_editor dtse_sva u_dtse_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

/* tb/sv/dtse_checker.sv */
// dtse_checker: watches both channels of date_time_set_editor, predicts each result word
// from the accepted input words and compares field by field. Depends on dtse_pkg.
`timescale 1ns / 100ps

module dtse_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  dtse_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  dtse_pkg::out_word_t out_word_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  dtse_pkg::held_t     ed;
  dtse_pkg::out_word_t shown_q[$];
  dtse_pkg::out_word_t want;
  int                  fails = 0;

  assign fail_count_o = fails;

  function automatic logic [4:0] month_days(logic [3:0] m);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      4'd2: return 5'd29;
      default: return 5'd31;
    endcase
  endfunction

  function automatic void step_month(bit up);
    if (up) begin
      if (ed.month >= dtse_pkg::MONTH_MAX) begin
        ed.month = 4'd1;
        if (ed.year < dtse_pkg::YEAR_MAX) ed.year = ed.year + 14'd1;
      end else begin
        ed.month = ed.month + 4'd1;
      end
    end else begin
      if (ed.month <= 4'd1) begin
        ed.month = dtse_pkg::MONTH_MAX;
        if (ed.year != 14'd0) ed.year = ed.year - 14'd1;
      end else begin
        ed.month = ed.month - 4'd1;
      end
    end
    if (ed.day > month_days(ed.month)) ed.day = month_days(ed.month);
  endfunction

  function automatic void step_day(bit up);
    if (up) begin
      if (ed.day >= month_days(ed.month)) begin
        ed.day = 5'd1;
        step_month(1'b1);
      end else begin
        ed.day = ed.day + 5'd1;
      end
    end else begin
      if (ed.day <= 5'd1) begin
        step_month(1'b0);
        ed.day = month_days(ed.month);
      end else begin
        ed.day = ed.day - 5'd1;
      end
    end
  endfunction

  function automatic void step_hour(bit up);
    if (up) ed.hour = (ed.hour >= dtse_pkg::HOUR_MAX) ? 5'd0 : ed.hour + 5'd1;
    else    ed.hour = (ed.hour == 5'd0) ? dtse_pkg::HOUR_MAX : ed.hour - 5'd1;
  endfunction

  function automatic void step_minute(bit up);
    if (up) begin
      if (ed.minute >= dtse_pkg::MINSEC_MAX) begin
        ed.minute = 6'd0;
        step_hour(1'b1);
      end else begin
        ed.minute = ed.minute + 6'd1;
      end
    end else begin
      if (ed.minute == 6'd0) begin
        ed.minute = dtse_pkg::MINSEC_MAX;
        step_hour(1'b0);
      end else begin
        ed.minute = ed.minute - 6'd1;
      end
    end
  endfunction

  function automatic void step_second(bit up);
    if (up) begin
      if (ed.second >= dtse_pkg::MINSEC_MAX) begin
        ed.second = 6'd0;
        step_minute(1'b1);
      end else begin
        ed.second = ed.second + 6'd1;
      end
    end else begin
      if (ed.second == 6'd0) begin
        ed.second = dtse_pkg::MINSEC_MAX;
        step_minute(1'b0);
      end else begin
        ed.second = ed.second - 6'd1;
      end
    end
  endfunction

  function automatic dtse_pkg::out_word_t apply_word(dtse_pkg::in_word_t w);
    dtse_pkg::out_word_t r;
    logic [3:0]          m;
    logic [4:0]          d;
    logic                commit;
    commit = 1'b0;
    if (w.mode == dtse_pkg::MODE_LOAD) begin
      m = w.load_month;
      if (m < 4'd1) m = 4'd1;
      if (m > dtse_pkg::MONTH_MAX) m = dtse_pkg::MONTH_MAX;
      d = (w.load_day == 5'd0) ? 5'd1 : w.load_day;
      ed.month  = m;
      ed.day    = (d > month_days(m)) ? month_days(m) : d;
      ed.year   = (w.load_year > dtse_pkg::YEAR_MAX) ? dtse_pkg::YEAR_MAX : w.load_year;
      ed.hour   = (w.load_hour > dtse_pkg::HOUR_MAX) ? dtse_pkg::HOUR_MAX : w.load_hour;
      ed.minute = (w.load_minute > dtse_pkg::MINSEC_MAX) ? dtse_pkg::MINSEC_MAX
                                                         : w.load_minute;
      ed.second = (w.load_second > dtse_pkg::MINSEC_MAX) ? dtse_pkg::MINSEC_MAX
                                                         : w.load_second;
      ed.cursor = dtse_pkg::CUR_DAY;
    end else begin
      case (w.button)
        dtse_pkg::BTN_UP, dtse_pkg::BTN_DOWN: begin
          case (ed.cursor)
            dtse_pkg::CUR_DAY:    step_day(w.button == dtse_pkg::BTN_UP);
            dtse_pkg::CUR_MONTH:  step_month(w.button == dtse_pkg::BTN_UP);
            dtse_pkg::CUR_YEAR: begin
              if (w.button == dtse_pkg::BTN_UP) begin
                if (ed.year < dtse_pkg::YEAR_MAX) ed.year = ed.year + 14'd1;
              end else if (ed.year != 14'd0) begin
                ed.year = ed.year - 14'd1;
              end
            end
            dtse_pkg::CUR_HOUR:   step_hour(w.button == dtse_pkg::BTN_UP);
            dtse_pkg::CUR_MINUTE: step_minute(w.button == dtse_pkg::BTN_UP);
            dtse_pkg::CUR_SECOND: step_second(w.button == dtse_pkg::BTN_UP);
            default: ;
          endcase
        end
        dtse_pkg::BTN_RIGHT: begin
          if (ed.cursor >= dtse_pkg::CUR_SAVED) ed.cursor = dtse_pkg::CUR_SAVED;
          else if (ed.cursor == dtse_pkg::CUR_SECOND) ed.cursor = dtse_pkg::CUR_DAY;
          else ed.cursor = ed.cursor + 3'd1;
        end
        dtse_pkg::BTN_LEFT: begin
          if (ed.cursor == dtse_pkg::CUR_DAY) ed.cursor = dtse_pkg::CUR_SECOND;
          else if (ed.cursor > dtse_pkg::CUR_SECOND) ed.cursor = dtse_pkg::CUR_SECOND;
          else ed.cursor = ed.cursor - 3'd1;
        end
        dtse_pkg::BTN_SAVE: begin
          ed.cursor = dtse_pkg::CUR_SAVED;
          commit    = 1'b1;
        end
        default: ;
      endcase
    end
    r.shown_day    = ed.day;
    r.shown_month  = ed.month;
    r.shown_year   = ed.year;
    r.shown_hour   = ed.hour;
    r.shown_minute = ed.minute;
    r.shown_second = ed.second;
    r.cursor       = ed.cursor;
    r.commit       = commit;
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ed = dtse_pkg::HELD_RESET;
      shown_q.delete();
      pending_o <= 0;
    end else begin
      // result side first: a word accepted now cannot have left the block yet
      if (out_valid_i && !out_stall_i) begin
        if (shown_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          want = shown_q.pop_front();
          check_field("shown_day", want.shown_day, out_word_i.shown_day);
          check_field("shown_month", want.shown_month, out_word_i.shown_month);
          check_field("shown_year", want.shown_year, out_word_i.shown_year);
          check_field("shown_hour", want.shown_hour, out_word_i.shown_hour);
          check_field("shown_minute", want.shown_minute, out_word_i.shown_minute);
          check_field("shown_second", want.shown_second, out_word_i.shown_second);
          check_field("cursor", want.cursor, out_word_i.cursor);
          check_field("commit", want.commit, out_word_i.commit);
        end
      end
      if (in_valid_i && !in_stall_i) shown_q.push_back(apply_word(in_word_i));
      pending_o <= shown_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: drives date_time_set_editor with directed and random load and button words
// under random idling and a long result hold-off; dtse_checker does the checking.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] BTN_SPARE6     = 3'd6;
  localparam logic [2:0] BTN_SPARE7     = 3'd7;
  localparam int         PHASE_WORDS    = 375;
  localparam int         HOLD_CYCLES    = 64;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  dtse_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  dtse_pkg::out_word_t out_word;
  int                  pending;
  int                  fail_count;
  int                  send_idle_pct = 26;
  int                  recv_stall_pct = 64;
  bit                  hold_pending = 1'b0;
  int                  quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  date_time_set_editor u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  dtse_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  function automatic dtse_pkg::in_word_t noise_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(dtse_pkg::in_word_t)-1:0];
  endfunction

  function automatic dtse_pkg::in_word_t load_word(int unsigned d, int unsigned m,
                                                   int unsigned y, int unsigned h,
                                                   int unsigned mi, int unsigned s);
    dtse_pkg::in_word_t w;
    w = noise_word();
    w.mode        = dtse_pkg::MODE_LOAD;
    w.load_day    = 5'(d);
    w.load_month  = 4'(m);
    w.load_year   = 14'(y);
    w.load_hour   = 5'(h);
    w.load_minute = 6'(mi);
    w.load_second = 6'(s);
    return w;
  endfunction

  function automatic dtse_pkg::in_word_t press_word(logic [2:0] b);
    dtse_pkg::in_word_t w;
    w = noise_word();
    w.mode   = dtse_pkg::MODE_BUTTON;
    w.button = b;
    return w;
  endfunction

  function automatic logic [2:0] pick_button();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return dtse_pkg::BTN_UP;
    if (r < 65) return dtse_pkg::BTN_DOWN;
    if (r < 77) return dtse_pkg::BTN_RIGHT;
    if (r < 89) return dtse_pkg::BTN_LEFT;
    if (r < 94) return dtse_pkg::BTN_SAVE;
    if (r < 96) return dtse_pkg::BTN_NONE;
    if (r < 98) return BTN_SPARE6;
    return BTN_SPARE7;
  endfunction

  function automatic dtse_pkg::in_word_t random_load();
    dtse_pkg::in_word_t w;
    int unsigned        pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      w = noise_word();
      w.mode = dtse_pkg::MODE_LOAD;
    end else if (pick < 6) begin
      // near the carry and saturation edges
      w = load_word($urandom_range(27, 31),
                    $urandom_range(1) ? ($urandom_range(1) ? 2 : 12) : $urandom_range(1, 12),
                    $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(9998, 9999),
                    $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(22, 23),
                    $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(58, 59),
                    $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(58, 59));
    end else begin
      w = load_word($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 9999),
                    $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    end
    return w;
  endfunction

  task automatic send_word(dtse_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // result side: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("date_time_set_editor test failed");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(load_word(0, 0, 0, 0, 0, 0));
    send_word(press_word(dtse_pkg::BTN_DOWN));
    send_word(load_word(31, 15, 16383, 31, 63, 63));
    send_word(press_word(dtse_pkg::BTN_UP));
    send_word(press_word(dtse_pkg::BTN_LEFT));
    send_word(press_word(dtse_pkg::BTN_UP));
    send_word(press_word(dtse_pkg::BTN_DOWN));
    send_word(press_word(dtse_pkg::BTN_RIGHT));
    send_word(load_word(31, 1, 2024, 0, 0, 0));
    send_word(press_word(dtse_pkg::BTN_RIGHT));
    send_word(press_word(dtse_pkg::BTN_UP));
    send_word(press_word(dtse_pkg::BTN_UP));
    send_word(press_word(dtse_pkg::BTN_RIGHT));
    send_word(press_word(dtse_pkg::BTN_DOWN));
    send_word(press_word(dtse_pkg::BTN_RIGHT));
    send_word(press_word(dtse_pkg::BTN_DOWN));
    send_word(press_word(dtse_pkg::BTN_NONE));
    send_word(press_word(BTN_SPARE6));
    send_word(press_word(BTN_SPARE7));
    send_word(press_word(dtse_pkg::BTN_SAVE));
    send_word(press_word(dtse_pkg::BTN_UP));
    send_word(press_word(dtse_pkg::BTN_RIGHT));
    send_word(press_word(dtse_pkg::BTN_SAVE));
    send_word(press_word(dtse_pkg::BTN_LEFT));
    send_word(load_word(31, 4, 9999, 12, 30, 30));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 26;
          recv_stall_pct = 64;
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 26;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 2 && i == 100) hold_pending = 1'b1;
        if ($urandom_range(99) < 8) send_word(random_load());
        else send_word(press_word(pick_button()));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("date_time_set_editor test passed");
    end else begin
      $display("date_time_set_editor test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dtse_pkg.sv
hw/rtl/dtse_edit.sv
hw/rtl/date_time_set_editor.sv
hw/rtl/dtse_checker.sv
tb/sv/dtse_checker.sv
tb/sv/tb_top.sv
